// ===== sv/fpdt_pkg.sv =====
package fpdt_pkg;

  localparam int FRACTION_BITS_DEF = 24;
  localparam int MAX_DECIMALS_DEF  = 9;

  localparam int WHOLE_W      = 32;
  localparam int FRAC_W       = 24;
  localparam int FW_W         = 5;
  localparam int DEC_W        = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 5;
  localparam int WHOLE_DIGITS = 10;
  localparam int ND_W         = 4;
  localparam int POS_W        = 5;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [FW_W-1:0] WIDTH_LIMIT = 5'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMALS    = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] BCD_NINE = 4'd9;

  typedef struct packed {
    logic                negative;
    logic [WHOLE_W-1:0]  whole_part;
    logic [FRAC_W-1:0]   fraction_part;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  // converted value handed from front to back
  typedef struct packed {
    logic                          neg;
    logic [WHOLE_DIGITS-1:0][3:0]  whole_digits;
    logic [ND_W-1:0]               num_digits;
    logic [DEC_W-1:0]              decimals;
    logic [FW_W-1:0]               width;
  } conv_entry_t;

endpackage

// ===== sv/fpdt_front.sv =====
module fpdt_front
  import fpdt_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int MAX_DECIMALS  = MAX_DECIMALS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  in_item_t                      in_data,
  input  logic [FW_W-1:0]               cfg_width,
  input  logic [DEC_W-1:0]              cfg_decimals,
  input  logic                          q_full,
  output logic                          push,
  output conv_entry_t                   entry,
  output logic [MAX_DECIMALS-1:0][3:0]  entry_frac
);

  localparam int CNT_W = $clog2(WHOLE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WHOLE_W - 1);
  localparam logic [DEC_W-1:0] DEC_MAX  = DEC_W'(MAX_DECIMALS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                       st_r, st_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [WHOLE_W-1:0]               sh_r, sh_nxt;
  logic [WHOLE_DIGITS-1:0][3:0]     bcd_r, bcd_nxt;
  logic [FRACTION_BITS-1:0]         rem_r, rem_nxt;
  logic [MAX_DECIMALS-1:0][3:0]     fd_r, fd_nxt;
  logic                             neg_r, neg_nxt;
  logic [DEC_W-1:0]                 dec_r, dec_nxt;
  logic [FW_W-1:0]                  wid_r, wid_nxt;

  logic [WHOLE_DIGITS-1:0][3:0]     bcd_adj;
  logic [WHOLE_DIGITS*4:0]          bcd_shift;
  logic [FRACTION_BITS+3:0]         prod;
  logic [FRACTION_BITS-1:0]         frac_in;
  logic                             accept;

  logic                             round_up;
  logic [MAX_DECIMALS-1:0]          nine_above;
  logic                             all_nine;
  logic                             carry;
  logic [MAX_DECIMALS-1:0][3:0]     fd_round;
  logic [WHOLE_DIGITS-1:0]          nine_below;
  logic [WHOLE_DIGITS-1:0][3:0]     wd_round;
  logic [ND_W-1:0]                  nd;

  assign busy   = (st_r != ST_IDLE);
  assign accept = start && !busy;

  // only the low FRACTION_BITS bits of the fraction count
  always_comb begin
    for (int i = 0; i < FRACTION_BITS; i++) begin
      frac_in[i] = (i < FRAC_W) ? in_data.fraction_part[i] : 1'b0;
    end
  end

  // double dabble step and fraction times ten
  always_comb begin
    for (int i = 0; i < WHOLE_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    bcd_shift = {bcd_adj, sh_r[WHOLE_W-1]};
    prod = ({4'b0, rem_r} << 3) + ({4'b0, rem_r} << 1);
  end

  // rounding of fraction digits, carry into whole digits
  always_comb begin
    round_up = rem_r[FRACTION_BITS-1];
    all_nine = 1'b1;
    for (int j = 0; j < MAX_DECIMALS; j++) begin
      if ((DEC_W'(j) < dec_r) && (fd_r[j] != BCD_NINE)) all_nine = 1'b0;
    end
    for (int i = 0; i < MAX_DECIMALS; i++) begin
      nine_above[i] = 1'b1;
      for (int j = 0; j < MAX_DECIMALS; j++) begin
        if ((j > i) && (DEC_W'(j) < dec_r) && (fd_r[j] != BCD_NINE)) nine_above[i] = 1'b0;
      end
      if (round_up && (DEC_W'(i) < dec_r) && nine_above[i]) begin
        fd_round[i] = (fd_r[i] == BCD_NINE) ? 4'd0 : fd_r[i] + 4'd1;
      end else begin
        fd_round[i] = fd_r[i];
      end
    end
    carry = round_up && all_nine;
    for (int i = 0; i < WHOLE_DIGITS; i++) begin
      nine_below[i] = 1'b1;
      for (int j = 0; j < WHOLE_DIGITS; j++) begin
        if ((j < i) && (bcd_r[j] != BCD_NINE)) nine_below[i] = 1'b0;
      end
      if (carry && nine_below[i]) begin
        wd_round[i] = (bcd_r[i] == BCD_NINE) ? 4'd0 : bcd_r[i] + 4'd1;
      end else begin
        wd_round[i] = bcd_r[i];
      end
    end
    nd = ND_W'(1);
    for (int i = 1; i < WHOLE_DIGITS; i++) begin
      if (wd_round[i] != 4'd0) nd = ND_W'(i + 1);
    end
  end

  assign push = (st_r == ST_FIN) && !q_full;

  always_comb begin
    entry.neg          = neg_r;
    entry.whole_digits = wd_round;
    entry.num_digits   = nd;
    entry.decimals     = dec_r;
    entry.width        = wid_r;
    entry_frac         = fd_round;
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    sh_nxt  = sh_r;
    bcd_nxt = bcd_r;
    rem_nxt = rem_r;
    fd_nxt  = fd_r;
    neg_nxt = neg_r;
    dec_nxt = dec_r;
    wid_nxt = wid_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt  = ST_CONV;
          cnt_nxt = '0;
          sh_nxt  = in_data.whole_part;
          bcd_nxt = '0;
          rem_nxt = frac_in;
          neg_nxt = in_data.negative;
          dec_nxt = (cfg_decimals > DEC_MAX) ? DEC_MAX : cfg_decimals;
          wid_nxt = (cfg_width > WIDTH_LIMIT) ? WIDTH_LIMIT : cfg_width;
        end
      end
      ST_CONV: begin
        bcd_nxt = bcd_shift[WHOLE_DIGITS*4-1:0];
        sh_nxt  = {sh_r[WHOLE_W-2:0], 1'b0};
        if (CNT_W'(dec_r) > cnt_r) begin
          rem_nxt = prod[FRACTION_BITS-1:0];
          for (int i = 0; i < MAX_DECIMALS; i++) begin
            if (cnt_r == CNT_W'(i)) fd_nxt[i] = prod[FRACTION_BITS+3:FRACTION_BITS];
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (push) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    rem_r <= rem_nxt;
    fd_r  <= fd_nxt;
    neg_r <= neg_nxt;
    dec_r <= dec_nxt;
    wid_r <= wid_nxt;
  end

endmodule

// ===== sv/fpdt_back.sv =====
module fpdt_back
  import fpdt_pkg::*;
#(
  parameter int MAX_DECIMALS = MAX_DECIMALS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  conv_entry_t                   entry,
  input  logic [MAX_DECIMALS-1:0][3:0]  entry_frac,
  output logic                          q_full,
  output logic                          out_strobe,
  output out_item_t                     out_data
);

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  conv_entry_t                    q_r      [QUEUE_DEPTH];
  logic [MAX_DECIMALS-1:0][3:0]   qf_r     [QUEUE_DEPTH];
  logic [QPTR_W-1:0]              wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0]              qcnt_r, qcnt_nxt;

  conv_entry_t                    cur_r, cur_nxt;
  logic [MAX_DECIMALS-1:0][3:0]   curf_r, curf_nxt;
  logic [POS_W-1:0]               pos_r, pos_nxt;
  logic [POS_W-1:0]               pad_r, pad_nxt;
  logic [POS_W-1:0]               lead_r, lead_nxt;
  logic [POS_W-1:0]               total_r, total_nxt;
  logic                           act_r, act_nxt;
  logic                           ostb_r;
  out_item_t                      odata_r, odata_nxt;

  conv_entry_t                    head;
  logic                           pop, last_now;
  logic [POS_W-1:0]               len, wid, pad, lead, widx, fidx;
  logic [3:0]                     wdig, fdig;

  assign q_full   = (qcnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head     = q_r[rp_r];
  assign last_now = act_r && (pos_r == total_r - POS_W'(1));
  assign pop      = (!act_r || last_now) && (qcnt_r != '0);

  // queue pointers
  always_comb begin
    wp_nxt   = push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt   = pop ? rp_r + QPTR_W'(1) : rp_r;
    qcnt_nxt = qcnt_r;
    if (push && !pop) qcnt_nxt = qcnt_r + QCNT_W'(1);
    if (pop && !push) qcnt_nxt = qcnt_r - QCNT_W'(1);
  end

  // layout of the next value's text
  always_comb begin
    len  = POS_W'(head.num_digits) + POS_W'(head.neg);
    wid  = head.width;
    pad  = (wid > len) ? wid - len : '0;
    lead = pad + len;
  end

  always_comb begin
    cur_nxt   = cur_r;
    curf_nxt  = curf_r;
    pad_nxt   = pad_r;
    lead_nxt  = lead_r;
    total_nxt = total_r;
    pos_nxt   = pos_r;
    act_nxt   = act_r;
    if (act_r) begin
      pos_nxt = pos_r + POS_W'(1);
      if (last_now) act_nxt = 1'b0;
    end
    if (pop) begin
      cur_nxt   = head;
      curf_nxt  = qf_r[rp_r];
      pad_nxt   = pad;
      lead_nxt  = lead;
      total_nxt = (head.decimals != '0) ? lead + POS_W'(head.decimals) + POS_W'(1) : lead;
      pos_nxt   = '0;
      act_nxt   = 1'b1;
    end
  end

  // character at the current position
  always_comb begin
    widx = lead_r - POS_W'(1) - pos_r;
    fidx = pos_r - lead_r - POS_W'(1);
    wdig = '0;
    for (int i = 0; i < WHOLE_DIGITS; i++) begin
      if (widx == POS_W'(i)) wdig = cur_r.whole_digits[i];
    end
    fdig = '0;
    for (int i = 0; i < MAX_DECIMALS; i++) begin
      if (fidx == POS_W'(i)) fdig = curf_r[i];
    end
    if (pos_r < pad_r) begin
      odata_nxt.character = CH_SPACE;
    end else if (cur_r.neg && (pos_r == pad_r)) begin
      odata_nxt.character = CH_MINUS;
    end else if (pos_r < lead_r) begin
      odata_nxt.character = CH_ZERO + {4'b0, wdig};
    end else if (pos_r == lead_r) begin
      odata_nxt.character = CH_DOT;
    end else begin
      odata_nxt.character = CH_ZERO + {4'b0, fdig};
    end
    odata_nxt.last = last_now;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r]  <= entry;
      qf_r[wp_r] <= entry_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      qcnt_r <= '0;
      act_r  <= 1'b0;
      ostb_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      qcnt_r <= qcnt_nxt;
      act_r  <= act_nxt;
      ostb_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    curf_r  <= curf_nxt;
    pad_r   <= pad_nxt;
    lead_r  <= lead_nxt;
    total_r <= total_nxt;
    pos_r   <= pos_nxt;
    odata_r <= odata_nxt;
  end

  assign out_strobe = ostb_r;
  assign out_data   = odata_r;

endmodule

// ===== sv/fixed_point_to_decimal_text_unit.sv =====
// a value enters the queue after a 32-step bit-serial binary-to-bcd conversion of the
// whole part and a rounding state that waits while the queue is full
// a new value is accepted only once the last one has entered the queue; a value's
// characters leave one per cycle from a 2-entry queue, overlapping the next conversion
// reset: synchronous, active low; field width returns to 0 and decimals to 1
// the receiver cannot stall: each character is strobed for exactly one cycle
module fixed_point_to_decimal_text_unit
  import fpdt_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int MAX_DECIMALS  = MAX_DECIMALS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_data,
  output logic                   out_strobe,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [FW_W-1:0]               fwidth_r, fwidth_nxt;
  logic [DEC_W-1:0]              decpl_r, decpl_nxt;
  logic                          push, q_full;
  conv_entry_t                   entry;
  logic [MAX_DECIMALS-1:0][3:0]  entry_frac;

  assign cfg_ready = 1'b1;

  always_comb begin
    fwidth_nxt = fwidth_r;
    decpl_nxt  = decpl_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FIELD_WIDTH: fwidth_nxt = cfg_data[FW_W-1:0];
        REG_DECIMALS:    decpl_nxt  = cfg_data[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwidth_r <= '0;
      decpl_r  <= DEC_W'(1);
    end else begin
      fwidth_r <= fwidth_nxt;
      decpl_r  <= decpl_nxt;
    end
  end

  fpdt_front #(
    .FRACTION_BITS(FRACTION_BITS),
    .MAX_DECIMALS (MAX_DECIMALS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .cfg_width   (fwidth_r),
    .cfg_decimals(decpl_r),
    .q_full      (q_full),
    .push        (push),
    .entry       (entry),
    .entry_frac  (entry_frac)
  );

  fpdt_back #(
    .MAX_DECIMALS(MAX_DECIMALS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .entry      (entry),
    .entry_frac (entry_frac),
    .q_full     (q_full),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== sv/fpdt_checker.sv =====
module fpdt_checker
  import fpdt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input out_item_t  out_data
);

  // an accepted request keeps the unit busy through the whole conversion
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  a_busy_held: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##32 busy)
    else $error("busy dropped before conversion finished");

  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("strobe after reset");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.character == CH_SPACE) || (out_data.character == CH_MINUS) ||
                   (out_data.character == CH_DOT) ||
                   ((out_data.character >= CH_ZERO) && (out_data.character <= CH_NINE)))
    else $error("illegal output character");

endmodule

bind fixed_point_to_decimal_text_unit fpdt_checker u_fpdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);

// ===== verif/tb_fixed_point_to_decimal_text_unit.sv =====
module tb_fixed_point_to_decimal_text_unit;
  import fpdt_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_VALUES  = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_strobe;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fixed_point_to_decimal_text_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // local copy of the format registers, reset values
  logic [FW_W-1:0]  fmt_width = '0;
  logic [DEC_W-1:0] fmt_decimals = DEC_W'(1);

  in_item_t  pending_values[$];
  out_item_t expected_text[$];
  out_item_t want;
  logic      took = 1'b0;
  logic      steady_feed = 1'b0;
  int        gap_left = 0;
  int        cycle_count = 0;
  int        fail_count = 0;
  int        values_sent = 0;
  int        chars_checked = 0;
  int        settings_used = 1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic push_char(logic [7:0] c);
    expected_text.push_back('{character: c, last: 1'b0});
  endtask

  // expected text of one value under the current format
  task automatic predict_text(in_item_t item);
    logic [FW_W-1:0] width;
    int              dec;
    int              nd;
    int              len;
    int              pad;
    logic [63:0]     whole;
    logic [63:0]     part;
    logic [63:0]     scale;
    logic [3:0]      whole_digits [11];
    logic [3:0]      frac_digits [MAX_DECIMALS_DEF];
    dec = (fmt_decimals > MAX_DECIMALS_DEF) ? MAX_DECIMALS_DEF : int'(fmt_decimals);
    width = (fmt_width > WIDTH_LIMIT) ? WIDTH_LIMIT : fmt_width;
    whole = 64'(item.whole_part);
    part = '0;
    scale = 64'd1;
    nd = 0;
    repeat (dec) scale = scale * 10;
    if (dec == 0) begin
      whole = whole + item.fraction_part[FRACTION_BITS_DEF-1];
    end else begin
      part = (64'(item.fraction_part) * scale + (64'd1 << (FRACTION_BITS_DEF - 1)))
             >> FRACTION_BITS_DEF;
      // rounding up to a whole unit carries into the integer part
      if (part >= scale) begin
        part = part - scale;
        whole = whole + 1;
      end
    end
    do begin
      whole_digits[nd] = 4'(whole % 10);
      whole = whole / 10;
      nd++;
    end while (whole != 0 && nd < 11);
    len = nd + int'(item.negative);
    pad = (int'(width) > len) ? int'(width) - len : 0;
    repeat (pad) push_char(CH_SPACE);
    if (item.negative) push_char(CH_MINUS);
    for (int i = nd - 1; i >= 0; i--) push_char(CH_ZERO + 8'(whole_digits[i]));
    if (dec != 0) begin
      push_char(CH_DOT);
      for (int i = 0; i < dec; i++) begin
        frac_digits[i] = 4'(part % 10);
        part = part / 10;
      end
      for (int i = dec - 1; i >= 0; i--) push_char(CH_ZERO + 8'(frac_digits[i]));
    end
    expected_text[expected_text.size() - 1].last = 1'b1;
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!start || took) begin
      if (gap_left != 0) begin
        start <= 1'b0;
        if (!busy) gap_left <= gap_left - 1;
      end else if (pending_values.size() != 0) begin
        in_data <= pending_values.pop_front();
        start <= 1'b1;
        gap_left <= steady_feed ? 0 : $urandom_range(0, 4);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // character monitor and request tracking
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still due",
               cycle_count, expected_text.size());
      $display("Some tests failed");
      $finish;
    end else if (!rst_n) begin
      took <= 1'b0;
    end else begin
      if (out_strobe) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character %h last %b", out_data.character, out_data.last);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_data.character !== want.character) begin
            $error("character: expected %h, got %h", want.character, out_data.character);
            fail_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_data.last);
            fail_count++;
          end
          chars_checked++;
        end
      end
      took <= start && !busy;
      if (start && !busy) begin
        predict_text(in_data);
        values_sent++;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FIELD_WIDTH) fmt_width = value;
    else fmt_decimals = value[DEC_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_format(logic [CFG_DATA_W-1:0] width, logic [CFG_DATA_W-1:0] decimals);
    write_reg(REG_FIELD_WIDTH, width);
    write_reg(REG_DECIMALS, decimals);
    settings_used++;
  endtask

  task automatic add_value(logic neg, logic [WHOLE_W-1:0] whole, logic [FRAC_W-1:0] frac);
    in_item_t item;
    item.negative = neg;
    item.whole_part = whole;
    item.fraction_part = frac;
    pending_values.push_back(item);
  endtask

  task automatic add_random_values(int count);
    in_item_t    item;
    logic [63:0] p;
    logic [63:0] m;
    int          d;
    repeat (count) begin
      item.negative = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: item.whole_part = $urandom;
        1: item.whole_part = $urandom_range(0, 99);
        2: item.whole_part = 32'hFFFF_FFFF - $urandom_range(0, 3);
        3: begin
          p = 64'd1;
          repeat ($urandom_range(0, 9)) p = p * 10;
          item.whole_part = 32'(p - $urandom_range(0, 1));
        end
        default: item.whole_part = $urandom_range(0, 99999);
      endcase
      case ($urandom_range(0, 5))
        0: item.fraction_part = FRAC_W'($urandom);
        1: item.fraction_part = FRAC_W'(24'h80_0000 + $urandom_range(0, 2) - 1);
        2: item.fraction_part = FRAC_W'(24'hFF_FFFF - $urandom_range(0, 255));
        3: item.fraction_part = FRAC_W'($urandom_range(0, 255));
        4: begin
          // land right on a rounding boundary of the current digit count
          d = (fmt_decimals > MAX_DECIMALS_DEF) ? MAX_DECIMALS_DEF : int'(fmt_decimals);
          p = 64'd1;
          repeat (d) p = p * 10;
          m = 64'($urandom) % p;
          item.fraction_part = FRAC_W'((((2 * m + 1) << (FRACTION_BITS_DEF - 1)) / p)
                                       + $urandom_range(0, 1));
        end
        default: item.fraction_part = FRAC_W'($urandom);
      endcase
      pending_values.push_back(item);
    end
  endtask

  task automatic wait_idle();
    while (pending_values.size() != 0 || start || busy || expected_text.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset format: no padding, one decimal
    add_value(1'b0, 32'd0, 24'd0);
    add_value(1'b1, 32'd0, 24'd0);
    add_value(1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF);
    add_value(1'b0, 32'd0, 24'h80_0000);
    add_value(1'b0, 32'd0, 24'h0C_CCCC);
    add_value(1'b0, 32'd12345, 24'hF3_3333);
    add_value(1'b1, 32'd12345, 24'hF3_3334);
    wait_idle();

    set_format(5'd16, 5'd9);
    add_value(1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF);
    add_value(1'b0, 32'd0, 24'd1);
    add_value(1'b1, 32'd1, 24'h80_0000);
    add_value(1'b0, 32'hFFFF_FFFF, 24'd0);
    wait_idle();

    // out-of-range width and decimals clamp
    set_format(5'd31, 5'h1F);
    add_value(1'b0, 32'd7, 24'd1);
    add_value(1'b1, 32'd0, 24'hFF_FFFF);
    wait_idle();

    // no decimals: the whole part rounds
    set_format(5'd0, 5'd0);
    add_value(1'b0, 32'd0, 24'h7F_FFFF);
    add_value(1'b1, 32'd0, 24'h80_0000);
    add_value(1'b0, 32'hFFFF_FFFF, 24'h80_0000);
    add_value(1'b1, 32'd0, 24'd0);
    add_value(1'b0, 32'd9, 24'hFF_FFFF);
    wait_idle();

    set_format(5'd3, 5'd2);
    add_value(1'b1, 32'd123456, 24'h28_F5C3);
    add_value(1'b0, 32'd5, 24'hFF_FFFF);
    add_value(1'b1, 32'd0, 24'd0);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_format(5'd16, 5'd9);
        1: set_format(5'd0, 5'd0);
        2: set_format(5'd31, 5'd15);
        default: set_format(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      endcase
      steady_feed = (ph % 3 == 1);
      add_random_values(PHASE_VALUES);
      wait_idle();
    end

    repeat (40) @(posedge clk);
    $display("sent %0d values under %0d format settings, checked %0d characters",
             values_sent, settings_used, chars_checked);
    $display("%0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== fixed_point_to_decimal_text_unit.f =====
sv/fpdt_pkg.sv
sv/fpdt_front.sv
sv/fpdt_back.sv
sv/fixed_point_to_decimal_text_unit.sv
sv/fpdt_checker.sv
verif/tb_fixed_point_to_decimal_text_unit.sv
